// ----- rtl/core/vint_pkg.sv -----
// Shared types and constants for the varint decoder.
`default_nettype none

package vint_pkg;

    localparam int unsigned GROUP_BITS   = 7;
    localparam int unsigned MAX_GROUPS   = 10;
    localparam int unsigned VALUE_W      = 64;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned SHIFT_W      = 7;

    localparam logic [7:0] PAYLOAD_MASK  = 8'h7F;
    localparam logic [7:0] MORE_MASK     = 8'h80;
    localparam logic [VALUE_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    localparam logic [COUNT_W-1:0] LAST_GROUP   = COUNT_W'(MAX_GROUPS);
    localparam logic [COUNT_W-1:0] SIGN_LIMIT   = COUNT_W'(MAX_GROUPS - 1);

    localparam int unsigned ADDR_W = 3;
    localparam logic [0:0] REG_SIGNED_MODE = 1'b0;

    typedef struct packed {
        logic signed_mode;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/vint_cfg.sv -----
// APB configuration register block for the varint decoder.
`default_nettype none

module vint_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vint_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output vint_pkg::cfg_t                   cfg
);

    logic signed_mode_reg;
    logic signed_mode_next;
    logic wr_en;
    logic hit;

    assign pready = 1'b1;
    assign hit    = (paddr[vint_pkg::ADDR_W-1 -: 1] == vint_pkg::REG_SIGNED_MODE);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_comb begin
        signed_mode_next = signed_mode_reg;
        if (wr_en) begin
            signed_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b1;
        end else begin
            signed_mode_reg <= signed_mode_next;
        end
    end

    assign prdata          = hit ? {31'b0, signed_mode_reg} : 32'b0;
    assign cfg.signed_mode = signed_mode_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vint_accum.sv -----
// Input register, group accumulator and result register of the varint decoder.
`default_nettype none

module vint_accum (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire vint_pkg::cfg_t               cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_in_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [vint_pkg::VALUE_W-1:0] m_value,
    output logic                              m_too_long
);

    logic                            in_valid_reg, in_valid_next;
    logic [7:0]                      in_byte_reg, in_byte_next;
    logic [vint_pkg::VALUE_W-1:0]    acc_reg, acc_next;
    logic [vint_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic                            out_valid_reg, out_valid_next;
    logic [vint_pkg::VALUE_W-1:0]    out_value_reg, out_value_next;
    logic                            out_long_reg, out_long_next;

    logic                            more;
    logic                            out_free;
    logic                            fire;
    logic                            in_range;
    logic [vint_pkg::SHIFT_W-1:0]    shift;
    logic [vint_pkg::SHIFT_W-1:0]    next_shift;
    logic [vint_pkg::VALUE_W-1:0]    group;
    logic [vint_pkg::VALUE_W-1:0]    acc_or;
    logic [vint_pkg::VALUE_W-1:0]    ext_mask;

    assign more     = (in_byte_reg & vint_pkg::MORE_MASK) != 8'b0;
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (more || out_free);
    assign s_ready  = !in_valid_reg || fire;

    assign in_range   = count_reg < vint_pkg::LAST_GROUP;
    assign shift      = vint_pkg::SHIFT_W'(count_reg) * vint_pkg::SHIFT_W'(vint_pkg::GROUP_BITS);
    assign next_shift = shift + vint_pkg::SHIFT_W'(vint_pkg::GROUP_BITS);
    assign group      = vint_pkg::VALUE_W'(in_byte_reg & vint_pkg::PAYLOAD_MASK);
    assign acc_or     = in_range ? (acc_reg | (group << shift)) : acc_reg;
    assign ext_mask   = (cfg.signed_mode && in_byte_reg[6] && (count_reg < vint_pkg::SIGN_LIMIT))
                        ? (vint_pkg::ALL_ONES << next_shift[5:0]) : '0;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_long_next  = out_long_reg;

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (fire) begin
            in_valid_next = 1'b0;
            if (more) begin
                acc_next   = acc_or;
                count_next = in_range ? count_reg + 1'b1 : count_reg;
                ovf_next   = ovf_reg || !in_range;
            end else begin
                out_valid_next = 1'b1;
                out_value_next = acc_or | ext_mask;
                out_long_next  = ovf_reg || !in_range;
                acc_next       = '0;
                count_next     = '0;
                ovf_next       = 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        out_value_reg <= out_value_next;
        out_long_reg  <= out_long_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_value    = out_value_reg;
    assign m_too_long = out_long_reg;

endmodule

`default_nettype wire

// ----- rtl/core/varint_decoder.sv -----
// Varint decoder: one encoded byte per cycle in, one decoded 64-bit value per varint out.
// A terminating byte passes from the input register to the result register (m_valid).
// Throughput: one byte per cycle, set by the single accumulate step between the input
// and result registers; a terminating byte stalls while an unaccepted result is held.
// Reset: synchronous, active low; clears the accumulator, group count, overflow
// flag and both valid flags, and sets signed_mode to 1.
`default_nettype none

module varint_decoder (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vint_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_in_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [63:0]               m_value,
    output logic                             m_too_long
);

    vint_pkg::cfg_t cfg;

    vint_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vint_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_too_long (m_too_long)
    );

endmodule

`default_nettype wire
